[rtl/core/gfa_pkg.sv]
// gfa_pkg: shared types, codes and constants for the gas and flood alarm filter.
// No dependencies; used by gfa_chan and gas_flood_alarm_filter_top.

package gfa_pkg;

    // Defaults for the top-level parameters
    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 10;

    // Full-scale spans of the fixed-point outputs
    localparam int METHANE_SPAN = 8000;
    localparam int SULFIDE_SPAN = 12800;
    localparam int WATER_SPAN   = 25600;

    // Width of a scaled channel value (covers the largest span)
    localparam int SCALED_BITS = 15;

    // Item kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_SILENCE   = 2'd1;
    localparam logic [1:0] KIND_UNSILENCE = 2'd2;

    // Alert cause codes
    localparam logic [1:0] CAUSE_CLEAR   = 2'd0;
    localparam logic [1:0] CAUSE_METHANE = 2'd1;
    localparam logic [1:0] CAUSE_SULFIDE = 2'd2;
    localparam logic [1:0] CAUSE_FLOOD   = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_METHANE_THR = 2'd0;
    localparam logic [1:0] REG_SULFIDE_THR = 2'd1;
    localparam logic [1:0] REG_WATER_THR   = 2'd2;

    localparam logic [9:0] METHANE_THR_RST = 10'd512;
    localparam logic [9:0] SULFIDE_THR_RST = 10'd205;
    localparam logic [9:0] WATER_THR_RST   = 10'd512;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] methane_sample;
        logic [9:0] sulfide_sample;
        logic [9:0] water_sample;
    } t_in_item;

    typedef struct packed {
        logic [12:0] methane_ppm_q2;
        logic [13:0] sulfide_ppm_q8;
        logic [14:0] water_level_q8;
        logic [14:0] headroom_q8;
        logic        methane_alert;
        logic        sulfide_alert;
        logic        water_alert;
        logic        any_alert;
        logic        alert_changed;
        logic [1:0]  alert_cause;
        logic        buzzer_on;
        logic        silenced;
    } t_out_item;

    // Pipeline control handed to each channel
    typedef struct packed {
        logic adv;      // whole pipeline moves this cycle
        logic s1_tick;  // stage 1 holds a valid sample tick
    } t_pipe_ctl;

    // Alarm flags carried down the pipeline after evaluation
    typedef struct packed {
        logic       tick;
        logic       methane_alert;
        logic       sulfide_alert;
        logic       water_alert;
        logic       any_alert;
        logic       alert_changed;
        logic [1:0] alert_cause;
        logic       buzzer_on;
        logic       silenced;
    } t_flags;

endpackage

[rtl/core/gas_flood_alarm_filter_top.sv]
// gas_flood_alarm_filter_top: three-channel moving-average alarm with buzzer control.
// Depends on gfa_pkg and gfa_chan; holds the sample ring memory and the APB registers.
//
//  channel   direction  payload              handshake
//  -------   ---------  -------------------  --------------------------------
//  in        sink       gfa_pkg::t_in_item   i_in_valid / o_in_stall
//  out       source     gfa_pkg::t_out_item  o_out_valid / i_out_stall
//  config    slave      10-bit thresholds    APB psel/penable/pwrite, pready=1
//
// One item per cycle unless the output stalls; each item passes stages 1 to 4 in order.
// Stage 1 reads the ring entry being replaced (registered memory read) and updates
// the running sums; stage 2 averages and evaluates the alarm state; stages 3-4 scale.
// Reset clears the sums, slot pointer, alarm state and the ring's valid bits.
// A stall on a held output item freezes the whole pipeline, and the input stalls with it.

module gas_flood_alarm_filter_top #(
    parameter int WINDOW      = gfa_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = gfa_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gfa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gfa_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SB   = SAMPLE_BITS;
    localparam int SLW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WW   = 3 * SB;
    localparam int CMPW = (SB > 10) ? SB : 10;

    // ---------------- configuration registers ----------------
    logic [9:0] r_methane_thr;
    logic [9:0] r_sulfide_thr;
    logic [9:0] r_water_thr;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_methane_thr <= gfa_pkg::METHANE_THR_RST;
            r_sulfide_thr <= gfa_pkg::SULFIDE_THR_RST;
            r_water_thr   <= gfa_pkg::WATER_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gfa_pkg::REG_METHANE_THR: r_methane_thr <= pwdata[9:0];
                gfa_pkg::REG_SULFIDE_THR: r_sulfide_thr <= pwdata[9:0];
                gfa_pkg::REG_WATER_THR:   r_water_thr   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gfa_pkg::REG_METHANE_THR: prdata = {22'd0, r_methane_thr};
            gfa_pkg::REG_SULFIDE_THR: prdata = {22'd0, r_sulfide_thr};
            gfa_pkg::REG_WATER_THR:   prdata = {22'd0, r_water_thr};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic accept;
    logic r_v1, r_v2, r_v3, r_v4;

    // everything moves unless a finished item is held at the output
    assign adv         = !(r_v4 && i_out_stall);
    assign accept      = i_in_valid && adv;
    assign o_in_stall  = !adv;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // ---------------- stage 0 -> 1: slot pointer and item capture ----------------
    logic [SLW-1:0] r_slot;
    logic [SLW-1:0] r_slot1;
    logic [1:0]     r_kind1;
    logic [WW-1:0]  r_samp1;
    logic           in_tick;

    assign in_tick = (i_in_data.kind == gfa_pkg::KIND_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (accept && in_tick) begin
            if (r_slot == SLW'(WINDOW - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + SLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind1 <= i_in_data.kind;
            r_slot1 <= r_slot;
            r_samp1 <= {SB'(i_in_data.methane_sample),
                        SB'(i_in_data.sulfide_sample),
                        SB'(i_in_data.water_sample)};
        end
    end

    // ---------------- sample ring memory ----------------
    logic [WW-1:0]     r_ring [WINDOW];
    logic [WW-1:0]     r_rdata;
    logic [WINDOW-1:0] r_ring_vld;
    logic              r_rd_vld;
    logic              r_fwd;
    logic [WW-1:0]     r_fwd_data;
    logic              s1_tick;
    logic              ring_wr;
    logic [WW-1:0]     old_word;

    assign s1_tick = r_v1 && (r_kind1 == gfa_pkg::KIND_TICK);
    assign ring_wr = adv && s1_tick;

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[r_slot1] <= r_samp1;
        end
        if (accept) begin
            r_rdata <= r_ring[r_slot];
        end
    end

    // entries never written read as zero; a same-cycle write to the read slot is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_rd_vld   <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (ring_wr) begin
                r_ring_vld[r_slot1] <= 1'b1;
            end
            if (accept) begin
                r_rd_vld <= r_ring_vld[r_slot];
                r_fwd    <= ring_wr && (r_slot1 == r_slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= r_samp1;
        end
    end

    always_comb begin
        if (r_fwd) begin
            old_word = r_fwd_data;
        end else if (r_rd_vld) begin
            old_word = r_rdata;
        end else begin
            old_word = '0;
        end
    end

    // ---------------- channels ----------------
    gfa_pkg::t_pipe_ctl        ctl;
    logic [SB-1:0]             avg_m, avg_s, avg_w;
    logic [gfa_pkg::SCALED_BITS-1:0] sc_m, sc_s, sc_w;

    assign ctl.adv     = adv;
    assign ctl.s1_tick = s1_tick;

    gfa_chan #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SB), .SPAN(gfa_pkg::METHANE_SPAN)
    ) u_methane (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_sample(r_samp1[2*SB +: SB]), .i_old(old_word[2*SB +: SB]),
        .o_avg(avg_m), .o_scaled(sc_m)
    );

    gfa_chan #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SB), .SPAN(gfa_pkg::SULFIDE_SPAN)
    ) u_sulfide (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_sample(r_samp1[SB +: SB]), .i_old(old_word[SB +: SB]),
        .o_avg(avg_s), .o_scaled(sc_s)
    );

    gfa_chan #(
        .WINDOW(WINDOW), .SAMPLE_BITS(SB), .SPAN(gfa_pkg::WATER_SPAN)
    ) u_water (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_sample(r_samp1[0 +: SB]), .i_old(old_word[0 +: SB]),
        .o_avg(avg_w), .o_scaled(sc_w)
    );

    // ---------------- stage 2: alarm evaluation and buzzer state ----------------
    logic [1:0]       r_kind2;
    logic             r_last_alert;
    logic             r_silence;
    logic             r_buzzer;
    logic             n_last_alert;
    logic             n_silence;
    logic             n_buzzer;
    logic             am, as, af, active, s2_tick;
    gfa_pkg::t_flags  s2_flags;
    gfa_pkg::t_flags  r_flags3;
    gfa_pkg::t_flags  r_flags4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind2 <= r_kind1;
        end
    end

    assign s2_tick = (r_kind2 == gfa_pkg::KIND_TICK);
    assign am      = CMPW'(avg_m) >= CMPW'(r_methane_thr);
    assign as      = CMPW'(avg_s) >= CMPW'(r_sulfide_thr);
    assign af      = CMPW'(avg_w) >= CMPW'(r_water_thr);
    assign active  = am || as || af;

    always_comb begin
        n_last_alert = r_last_alert;
        n_silence    = r_silence;
        n_buzzer     = r_buzzer;
        case (r_kind2)
            gfa_pkg::KIND_TICK: begin
                n_last_alert = active;
                if (active && !r_silence) begin
                    n_buzzer = 1'b1;
                end else begin
                    n_buzzer = 1'b0;
                    if (!active) begin
                        n_silence = 1'b0;
                    end
                end
            end
            gfa_pkg::KIND_SILENCE: begin
                n_silence = 1'b1;
                n_buzzer  = 1'b0;
            end
            gfa_pkg::KIND_UNSILENCE: begin
                n_silence = 1'b0;
            end
            default: ;
        endcase

        s2_flags.tick          = s2_tick;
        s2_flags.methane_alert = s2_tick && am;
        s2_flags.sulfide_alert = s2_tick && as;
        s2_flags.water_alert   = s2_tick && af;
        s2_flags.any_alert     = s2_tick ? active : r_last_alert;
        s2_flags.alert_changed = s2_tick && (active != r_last_alert);
        if (!s2_tick) begin
            s2_flags.alert_cause = gfa_pkg::CAUSE_CLEAR;
        end else if (am) begin
            s2_flags.alert_cause = gfa_pkg::CAUSE_METHANE;
        end else if (as) begin
            s2_flags.alert_cause = gfa_pkg::CAUSE_SULFIDE;
        end else if (af) begin
            s2_flags.alert_cause = gfa_pkg::CAUSE_FLOOD;
        end else begin
            s2_flags.alert_cause = gfa_pkg::CAUSE_CLEAR;
        end
        s2_flags.buzzer_on = n_buzzer;
        s2_flags.silenced  = n_silence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_alert <= 1'b0;
            r_silence    <= 1'b0;
            r_buzzer     <= 1'b0;
        end else if (adv && r_v2) begin
            r_last_alert <= n_last_alert;
            r_silence    <= n_silence;
            r_buzzer     <= n_buzzer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flags3 <= s2_flags;
            r_flags4 <= r_flags3;
        end
    end

    // ---------------- stage 4: output item ----------------
    always_comb begin
        o_out_data.methane_ppm_q2 = r_flags4.tick ? sc_m[12:0] : '0;
        o_out_data.sulfide_ppm_q8 = r_flags4.tick ? sc_s[13:0] : '0;
        o_out_data.water_level_q8 = r_flags4.tick ? sc_w : '0;
        o_out_data.headroom_q8    =
            r_flags4.tick ? (15'(gfa_pkg::WATER_SPAN) - sc_w) : '0;
        o_out_data.methane_alert  = r_flags4.methane_alert;
        o_out_data.sulfide_alert  = r_flags4.sulfide_alert;
        o_out_data.water_alert    = r_flags4.water_alert;
        o_out_data.any_alert      = r_flags4.any_alert;
        o_out_data.alert_changed  = r_flags4.alert_changed;
        o_out_data.alert_cause    = r_flags4.alert_cause;
        o_out_data.buzzer_on      = r_flags4.buzzer_on;
        o_out_data.silenced       = r_flags4.silenced;
    end

endmodule

[rtl/core/gfa_chan.sv]
// gfa_chan: running window sum, average and fixed-point scaling of one channel.
// Depends on gfa_pkg; the ring memory that feeds i_old lives in the top level.

module gfa_chan #(
    parameter int WINDOW      = gfa_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = gfa_pkg::SAMPLE_BITS_DEF,
    parameter int SPAN        = gfa_pkg::WATER_SPAN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gfa_pkg::t_pipe_ctl                 i_ctl,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    input  logic [SAMPLE_BITS-1:0]             i_old,
    output logic [SAMPLE_BITS-1:0]             o_avg,
    output logic [gfa_pkg::SCALED_BITS-1:0]    o_scaled
);

    localparam int SW   = gfa_pkg::SCALED_BITS;
    localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW);
    // floor(x / WINDOW) = (x * MW) >> KW, exact for x < 2^SUMW
    localparam int KW   = SUMW + $clog2(WINDOW);
    localparam logic [63:0] MW64 =
        ((64'd1 << KW) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUMW:0] MW = MW64[SUMW:0];
    localparam int QW   = 2 * SUMW + 1;

    // floor(y / FULL) = (y * MF) >> KF, exact for y < 2^YW
    localparam int YW   = SAMPLE_BITS + SW;
    localparam int KF   = YW + SAMPLE_BITS;
    localparam logic [63:0] FULL64 = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [63:0] MF64 = ((64'd1 << KF) + FULL64 - 64'd1) / FULL64;
    localparam logic [YW:0] MF = MF64[YW:0];
    localparam int FW   = 2 * YW + 1;

    logic [SUMW-1:0] r_sum;
    logic [SUMW-1:0] n_sum;
    logic [QW-1:0]   r_qprod;
    logic [YW-1:0]   r_y;
    logic [FW-1:0]   r_fprod;

    assign n_sum = r_sum - SUMW'(i_old) + SUMW'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.adv && i_ctl.s1_tick) begin
            r_sum <= n_sum;
        end
    end

    // stage 2: quotient product, stage 3: scaled product, stage 4: reciprocal product
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_qprod <= QW'(n_sum) * QW'(MW);
            r_y     <= YW'(o_avg) * YW'(SPAN);
            r_fprod <= FW'(r_y) * FW'(MF);
        end
    end

    assign o_avg    = r_qprod[KW +: SAMPLE_BITS];
    assign o_scaled = r_fprod[KF +: SW];

endmodule

[bench/gfa_checker.sv]
`timescale 1ns / 100ps
// gfa_checker: scoreboard for gas_flood_alarm_filter_top. It follows register writes
// and accepted items, works out each result and compares results in arrival order.
// Depends on gfa_pkg for the item structs, kinds, cause codes and register indexes.

module gfa_checker
    import gfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_results,
    output int          o_alert_edges
);

    localparam int FULL  = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int DEPTH = WINDOW_DEF;

    localparam int CH_METHANE = 0;
    localparam int CH_SULFIDE = 1;
    localparam int CH_WATER   = 2;

    logic [9:0] history [3][DEPTH];
    int         slot;
    logic [9:0] methane_thr;
    logic [9:0] sulfide_thr;
    logic [9:0] water_thr;
    logic       last_alert;
    logic       silence_latch;
    logic       buzzer_level;

    t_out_item  expected_reports [$];
    int         mismatches  = 0;
    int         outstanding = 0;
    int         results     = 0;
    int         alert_edges = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_results     = results;
    assign o_alert_edges = alert_edges;

    function automatic int ring_average(input int ch);
        int sum;
        sum = 0;
        for (int i = 0; i < DEPTH; i++) sum += history[ch][i];
        return sum / DEPTH;
    endfunction

    function automatic logic [14:0] to_units(input int avg, input int span_full);
        return 15'((avg * span_full) / FULL);
    endfunction

    // Advances the mirrored filter state by one item and returns its result.
    function automatic t_out_item alarm_response(input t_in_item it);
        t_out_item r;
        int        avg_m;
        int        avg_s;
        int        avg_w;
        logic      m_hit;
        logic      s_hit;
        logic      f_hit;
        logic      any_hit;
        r = '0;
        case (it.kind)
            KIND_TICK: begin
                history[CH_METHANE][slot] = it.methane_sample;
                history[CH_SULFIDE][slot] = it.sulfide_sample;
                history[CH_WATER][slot]   = it.water_sample;
                slot = (slot + 1) % DEPTH;
                avg_m = ring_average(CH_METHANE);
                avg_s = ring_average(CH_SULFIDE);
                avg_w = ring_average(CH_WATER);
                m_hit = (avg_m >= methane_thr);
                s_hit = (avg_s >= sulfide_thr);
                f_hit = (avg_w >= water_thr);
                any_hit = m_hit | s_hit | f_hit;
                r.methane_ppm_q2 = 13'(to_units(avg_m, METHANE_SPAN));
                r.sulfide_ppm_q8 = 14'(to_units(avg_s, SULFIDE_SPAN));
                r.water_level_q8 = to_units(avg_w, WATER_SPAN);
                r.headroom_q8    = 15'(WATER_SPAN) - r.water_level_q8;
                r.methane_alert  = m_hit;
                r.sulfide_alert  = s_hit;
                r.water_alert    = f_hit;
                r.any_alert      = any_hit;
                r.alert_changed  = (any_hit != last_alert);
                r.alert_cause    = m_hit ? CAUSE_METHANE :
                                   s_hit ? CAUSE_SULFIDE :
                                   f_hit ? CAUSE_FLOOD : CAUSE_CLEAR;
                last_alert = any_hit;
                if (any_hit && !silence_latch) begin
                    buzzer_level = 1'b1;
                end else begin
                    buzzer_level = 1'b0;
                    if (!any_hit) silence_latch = 1'b0;
                end
            end
            KIND_SILENCE: begin
                silence_latch  = 1'b1;
                buzzer_level   = 1'b0;
                r.any_alert    = last_alert;
            end
            KIND_UNSILENCE: begin
                silence_latch  = 1'b0;
                r.any_alert    = last_alert;
            end
            default: begin
                // unused kind: no state change
                r.any_alert    = last_alert;
            end
        endcase
        r.buzzer_on = buzzer_level;
        r.silenced  = silence_latch;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result %0d field %s expected %0d got %0d",
                         $time, results, name, want, got);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result arrived with nothing outstanding: %p", $time, got);
        end else begin
            want = expected_reports.pop_front();
            compare_field("methane_ppm_q2", want.methane_ppm_q2, got.methane_ppm_q2);
            compare_field("sulfide_ppm_q8", want.sulfide_ppm_q8, got.sulfide_ppm_q8);
            compare_field("water_level_q8", want.water_level_q8, got.water_level_q8);
            compare_field("headroom_q8",    want.headroom_q8,    got.headroom_q8);
            compare_field("methane_alert",  want.methane_alert,  got.methane_alert);
            compare_field("sulfide_alert",  want.sulfide_alert,  got.sulfide_alert);
            compare_field("water_alert",    want.water_alert,    got.water_alert);
            compare_field("any_alert",      want.any_alert,      got.any_alert);
            compare_field("alert_changed",  want.alert_changed,  got.alert_changed);
            compare_field("alert_cause",    want.alert_cause,    got.alert_cause);
            compare_field("buzzer_on",      want.buzzer_on,      got.buzzer_on);
            compare_field("silenced",       want.silenced,       got.silenced);
            if (want.alert_changed) alert_edges++;
        end
        results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++)
                for (int i = 0; i < DEPTH; i++) history[c][i] = '0;
            slot          = 0;
            methane_thr   = METHANE_THR_RST;
            sulfide_thr   = SULFIDE_THR_RST;
            water_thr     = WATER_THR_RST;
            last_alert    = 1'b0;
            silence_latch = 1'b0;
            buzzer_level  = 1'b0;
            expected_reports.delete();
            outstanding   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_METHANE_THR: methane_thr = pwdata[9:0];
                    REG_SULFIDE_THR: sulfide_thr = pwdata[9:0];
                    REG_WATER_THR:   water_thr   = pwdata[9:0];
                    default: ;
                endcase
            end
            // results leave only after their item passes the pipeline, so pop before push
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_in_valid && !i_in_stall) expected_reports.push_back(alarm_response(i_in_data));
            outstanding = expected_reports.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// testbench: stimulus and verdict for gas_flood_alarm_filter_top.
// Depends on gfa_pkg, the filter RTL and gfa_checker, which does all result checking.

module testbench;
    import gfa_pkg::*;

    localparam int  ITEMS       = 1900;      // random items, unused kind not counted
    localparam int  HOLD_CYCLES = 200;       // long receiver hold-off
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 16;        // longer than the pipeline latency

    // Kind code the block ignores; the package names only the three real kinds.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_pattern;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int results;
    int alert_edges;

    int cycle_count    = 0;
    int random_items   = 0;
    int settings_count = 0;
    bit hold_request   = 1'b0;
    int level [3];    // slowly wandering reading per channel

    // ------------------------------------------------------------------
    // Clock, 10 ns period
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Block under test and its scoreboard side by side
    // ------------------------------------------------------------------
    gas_flood_alarm_filter_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gfa_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_results    (results),
        .o_alert_edges(alert_edges)
    );

    // ------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run here
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns of random length, plus one long hold-off
    // on request. The hold-off is counted here so the sender keeps
    // offering items and the pipeline backs up into o_in_stall.
    // ------------------------------------------------------------------
    initial begin : receiver
        int             left;
        int             held;
        t_stall_pattern pattern;
        left    = 0;
        held    = 0;
        pattern = STALL_NONE;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                held++;
                if (held == HOLD_CYCLES) begin
                    hold_request = 1'b0;
                    held = 0;
                end
            end else begin
                if (left == 0) begin
                    pattern = t_stall_pattern'($urandom_range(0, 3));
                    left    = $urandom_range(16, 128);
                end
                left--;
                case (pattern)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 20);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                    default:     out_stall <= (left % 5 < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side helpers. Inputs move on the falling edge; acceptance
    // is judged on the rising edge. Valid stays up across back-to-back
    // items, so it is driven once per falling edge at most.
    // ------------------------------------------------------------------
    task automatic send(input t_in_item it);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Sender goes quiet until every item has produced its result.
    task automatic wait_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [1:0] index, input logic [9:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {22'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New thresholds only once the filter has gone idle.
    task automatic set_thresholds(input logic [9:0] m, input logic [9:0] s,
                                  input logic [9:0] w);
        wait_drain();
        write_register(REG_METHANE_THR, m);
        write_register(REG_SULFIDE_THR, s);
        write_register(REG_WATER_THR, w);
        settings_count++;
    endtask

    function automatic t_in_item tick(input logic [9:0] m, input logic [9:0] s,
                                      input logic [9:0] w);
        t_in_item it;
        it.kind           = KIND_TICK;
        it.methane_sample = m;
        it.sulfide_sample = s;
        it.water_sample   = w;
        return it;
    endfunction

    // Command items carry random sample bits; the block must ignore them.
    function automatic t_in_item command(input logic [1:0] kind);
        t_in_item it;
        it      = t_in_item'($urandom);
        it.kind = kind;
        return it;
    endfunction

    // Readings mostly wander around a level so averages drift across the
    // thresholds; now and then a rail value or a jump.
    function automatic logic [9:0] next_reading(input int ch);
        int pick;
        int step;
        pick = $urandom_range(0, 99);
        if (pick < 6) return 10'd0;
        if (pick < 12) return 10'd1023;
        if (pick < 18) begin
            level[ch] = $urandom_range(0, 1023);
        end else begin
            step = $urandom_range(0, 96) - 48;
            level[ch] = level[ch] + step;
            if (level[ch] < 0) level[ch] = 0;
            if (level[ch] > 1023) level[ch] = 1023;
        end
        return 10'(level[ch]);
    endfunction

    function automatic t_in_item random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 84) return tick(next_reading(0), next_reading(1), next_reading(2));
        if (pick < 92) return command(KIND_SILENCE);
        if (pick < 98) return command(KIND_UNSILENCE);
        return command(KIND_UNUSED);
    endfunction

    function automatic logic [9:0] random_threshold();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) return 10'd0;
        if (pick < 24) return 10'd1023;
        return 10'($urandom_range(150, 900));
    endfunction

    // Random items in bursts; with gaps off the sender never idles.
    task automatic run_random(input int count, input bit gaps);
        int       sent;
        int       burst;
        t_in_item it;
        sent  = 0;
        burst = $urandom_range(1, 40);
        while (sent < count) begin
            it = random_item();
            send(it);
            if (it.kind != KIND_UNUSED) sent++;
            burst--;
            if (burst == 0) begin
                if (gaps)
                    pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
        end
        random_items += sent;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        for (int c = 0; c < 3; c++) level[c] = 512;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset thresholds (512 / 205 / 512).
        send(tick(10'd0, 10'd0, 10'd0));              // all clear, full headroom
        // Rings fill with full scale: average 204 sits just under the sulfide
        // threshold, then sulfide trips, then methane takes over the cause.
        repeat (5) send(tick(10'd1023, 10'd1023, 10'd1023));
        send(command(KIND_SILENCE));                  // buzzer drops, latch set
        send(tick(10'd1023, 10'd1023, 10'd1023));     // still alarmed, stays quiet
        send(command(KIND_UNSILENCE));                // latch clears, buzzer as is
        send(tick(10'd1023, 10'd1023, 10'd1023));     // buzzer back on
        send(command(KIND_UNUSED));                   // ignored kind
        send(command(KIND_SILENCE));
        // Averages decay; the latch clears on the first tick without an alert.
        repeat (5) send(tick(10'd0, 10'd0, 10'd0));
        // Water alone rises to a flood cause.
        repeat (3) send(tick(10'd0, 10'd0, 10'd1023));
        send(command(KIND_UNSILENCE));

        // Threshold extremes: zero alarms on everything, full scale only on
        // a ring of all 1023.
        set_thresholds(10'd0, 10'd0, 10'd0);
        send(tick(10'd0, 10'd0, 10'd0));
        run_random(60, 1'b1);
        set_thresholds(10'd1023, 10'd1023, 10'd1023);
        repeat (5) send(tick(10'd1023, 10'd1023, 10'd1023));
        run_random(60, 1'b1);

        phase = 0;
        while (random_items < ITEMS) begin
            phase++;
            set_thresholds(random_threshold(), random_threshold(), random_threshold());
            if (phase == 2) begin
                // long receiver hold-off while the sender keeps pushing
                hold_request = 1'b1;
                run_random(60, 1'b0);
            end
            run_random(300, phase[0]);
        end

        wait_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d random items and %0d results over %0d threshold settings,",
                 random_items, results, settings_count);
        $display("with %0d alert edges seen and %0d field mismatches.",
                 alert_edges, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[gas_flood_alarm_filter_top.f]
rtl/core/gfa_pkg.sv
rtl/core/gfa_chan.sv
rtl/core/gas_flood_alarm_filter_top.sv
bench/gfa_checker.sv
bench/testbench.sv
